// ===== design/peak_meter_overload_lamps_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the peak meter block
// Immediate-consequence and next-cycle property forms, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PEAK_METER_OVERLOAD_LAMPS_ASSERT_SVH
`define PEAK_METER_OVERLOAD_LAMPS_ASSERT_SVH

// consequence checked in the same cycle
`define PMOL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequence checked in the cycle after the antecedent
`define PMOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pmol_pkg.sv =====
// ----------------------------------------------------------------------------
// pmol_pkg
// Shared types and constants of the stereo peak meter with held lamps.
// ----------------------------------------------------------------------------
`default_nettype none

package pmol_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int HOLD_BITS_DEF   = 16;

   // Q15 coefficients, kept positive in a signed word
   localparam int COEF_BITS = 17;
   localparam int Q15_SHIFT = 15;
   localparam logic signed [COEF_BITS-1:0] GAIN_Q15  = 17'sd31457;  // 0.96
   localparam logic signed [COEF_BITS-1:0] DECAY_Q15 = 17'sd32440;  // 0.99

   localparam int MODE_BITS      = 2;
   localparam int STEREO_BITS    = 2;
   localparam int LEVEL_BITS     = 15;
   localparam int HOLD_REG_BITS  = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam int LAMPS_PER_LANE = 3;
   localparam int LAMP_LOW       = 0;
   localparam int LAMP_HIGH      = 1;
   localparam int LAMP_CLIP      = 2;

   localparam logic [STEREO_BITS-1:0] STEREO_TWO = 2'd2;

   typedef enum logic [MODE_BITS-1:0] {
      MODE_AUDIO = 2'd0,
      MODE_CV    = 2'd1,
      MODE_IDLE  = 2'd2
   } meter_mode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_METER_MODE    = 3'd0,
      REG_STEREO_ENABLE = 3'd1,
      REG_OVL_LOW       = 3'd2,
      REG_OVL_HIGH      = 3'd3,
      REG_CLIP_LEVEL    = 3'd4,
      REG_HOLD_FRAMES   = 3'd5
   } csr_reg_type;

   localparam logic [MODE_BITS-1:0]     RST_MODE   = MODE_AUDIO;
   localparam logic [STEREO_BITS-1:0]   RST_STEREO = 2'd2;
   localparam logic [LEVEL_BITS-1:0]    RST_LOW    = 15'd27853;
   localparam logic [LEVEL_BITS-1:0]    RST_HIGH   = 15'd29491;
   localparam logic [LEVEL_BITS-1:0]    RST_CLIP   = 15'd31130;
   localparam logic [HOLD_REG_BITS-1:0] RST_HOLD   = 16'd100;

   typedef struct packed {
      logic [MODE_BITS-1:0]     mode;
      logic [STEREO_BITS-1:0]   stereo;
      logic [LEVEL_BITS-1:0]    low_level;
      logic [LEVEL_BITS-1:0]    high_level;
      logic [LEVEL_BITS-1:0]    clip_level;
      logic [HOLD_REG_BITS-1:0] hold_frames;
   } pmol_cfg_type;

   typedef struct packed {
      logic                     audio;     // meter and count this frame
      logic                     meter_en;  // channel is metered
      logic                     cv_copy;   // peak takes the raw sample
      logic [LEVEL_BITS-1:0]    low_level;
      logic [LEVEL_BITS-1:0]    high_level;
      logic [LEVEL_BITS-1:0]    clip_level;
      logic [HOLD_REG_BITS-1:0] hold_frames;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== design/pmol_csr.sv =====
// ----------------------------------------------------------------------------
// pmol_csr
// Configuration register file, one write per transfer on the csr channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pmol_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_en,
   input  logic [pmol_pkg::CSR_INDEX_BITS-1:0]   wr_index,
   input  logic [pmol_pkg::CSR_DATA_BITS-1:0]    wr_data,
   output pmol_pkg::pmol_cfg_type                cfg
);
   import pmol_pkg::*;

   pmol_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_METER_MODE:    cfg_in.mode        = wr_data[MODE_BITS-1:0];
            REG_STEREO_ENABLE: cfg_in.stereo      = wr_data[STEREO_BITS-1:0];
            REG_OVL_LOW:       cfg_in.low_level   = wr_data[LEVEL_BITS-1:0];
            REG_OVL_HIGH:      cfg_in.high_level  = wr_data[LEVEL_BITS-1:0];
            REG_CLIP_LEVEL:    cfg_in.clip_level  = wr_data[LEVEL_BITS-1:0];
            REG_HOLD_FRAMES:   cfg_in.hold_frames = wr_data[HOLD_REG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= RST_MODE;
         cfg_ff.stereo      <= RST_STEREO;
         cfg_ff.low_level   <= RST_LOW;
         cfg_ff.high_level  <= RST_HIGH;
         cfg_ff.clip_level  <= RST_CLIP;
         cfg_ff.hold_frames <= RST_HOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/pmol_lane.sv =====
// ----------------------------------------------------------------------------
// pmol_lane
// One channel: input gain stage, peak follower and three held lamps.
// ----------------------------------------------------------------------------
`default_nettype none

module pmol_lane #(
   parameter int SAMPLE_BITS = pmol_pkg::SAMPLE_BITS_DEF,
   parameter int HOLD_BITS   = pmol_pkg::HOLD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_load,
   input  logic signed [SAMPLE_BITS-1:0]         in_sample,
   input  logic                                  upd,
   input  pmol_pkg::lane_ctl_type                ctl,
   output logic signed [SAMPLE_BITS-1:0]         peak,
   output logic [pmol_pkg::LAMPS_PER_LANE-1:0]   lamps
);
   import pmol_pkg::*;

   localparam int ProdBits   = SAMPLE_BITS + COEF_BITS;
   localparam int CmpBits    = (SAMPLE_BITS > LEVEL_BITS ? SAMPLE_BITS : LEVEL_BITS) + 1;
   localparam int CntCmpBits = HOLD_BITS > HOLD_REG_BITS ? HOLD_BITS : HOLD_REG_BITS;
   localparam logic [HOLD_BITS-1:0] CntMax = {HOLD_BITS{1'b1}};

   logic signed [ProdBits-1:0]    gain_prod;
   logic signed [ProdBits-1:0]    decay_prod;
   logic signed [SAMPLE_BITS-1:0] scaled_ff;
   logic signed [SAMPLE_BITS-1:0] raw_ff;
   logic signed [SAMPLE_BITS-1:0] decayed;
   logic signed [SAMPLE_BITS-1:0] peak_ff, peak_in;
   logic signed [CmpBits-1:0]     scaled_ext;
   logic signed [CmpBits-1:0]     level_ext [LAMPS_PER_LANE];
   logic [LEVEL_BITS-1:0]         level [LAMPS_PER_LANE];
   logic [LAMPS_PER_LANE-1:0]     lamp_ff, lamp_in;
   logic [HOLD_BITS-1:0]          cnt_ff [LAMPS_PER_LANE];
   logic [HOLD_BITS-1:0]          cnt_in [LAMPS_PER_LANE];
   logic [HOLD_BITS-1:0]          cnt_inc [LAMPS_PER_LANE];
   logic                          metering;

   // gain stage, registered before the peak loop
   assign gain_prod = ProdBits'(in_sample) * ProdBits'(GAIN_Q15);

   always_ff @(posedge clock) begin
      if (in_load) begin
         scaled_ff <= gain_prod[Q15_SHIFT +: SAMPLE_BITS];
         raw_ff    <= in_sample;
      end
   end

   assign decay_prod = ProdBits'(peak_ff) * ProdBits'(DECAY_Q15);
   assign decayed    = decay_prod[Q15_SHIFT +: SAMPLE_BITS];
   assign metering   = ctl.audio & ctl.meter_en;

   always_comb begin
      if (metering) begin
         peak_in = (scaled_ff > peak_ff) ? scaled_ff : decayed;
      end else if (ctl.cv_copy) begin
         peak_in = raw_ff;
      end else begin
         peak_in = peak_ff;
      end
   end

   assign level[LAMP_LOW]  = ctl.low_level;
   assign level[LAMP_HIGH] = ctl.high_level;
   assign level[LAMP_CLIP] = ctl.clip_level;
   assign scaled_ext       = CmpBits'(scaled_ff);

   always_comb begin
      for (int i = 0; i < LAMPS_PER_LANE; i++) begin
         level_ext[i] = $signed(CmpBits'(level[i]));
         cnt_inc[i]   = (cnt_ff[i] == CntMax) ? cnt_ff[i] : cnt_ff[i] + 1'b1;
         lamp_in[i]   = lamp_ff[i] | (metering & (scaled_ext > level_ext[i]));
         cnt_in[i]    = cnt_ff[i];
         if (ctl.audio && lamp_in[i]) begin
            cnt_in[i] = cnt_inc[i];
            if (CntCmpBits'(cnt_inc[i]) >= CntCmpBits'(ctl.hold_frames)) begin
               lamp_in[i] = 1'b0;
               cnt_in[i]  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
         lamp_ff <= '0;
         for (int i = 0; i < LAMPS_PER_LANE; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (upd) begin
         peak_ff <= peak_in;
         lamp_ff <= lamp_in;
         for (int i = 0; i < LAMPS_PER_LANE; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   assign peak  = peak_ff;
   assign lamps = lamp_ff;

endmodule

`default_nettype wire

// ===== design/peak_meter_overload_lamps.sv =====
// ----------------------------------------------------------------------------
// peak_meter_overload_lamps
// Stereo peak meter with held overload and clip lamps, two channel lanes.
// ----------------------------------------------------------------------------
//   channel  dir  ports                          payload
//   req      in   req_tvalid/tready/tdata        sample_left, sample_right
//   rsp      out  rsp_tvalid/tready/tdata        peaks, six lamps
//   csr      in   csr_valid/ready/index/data     register write
//
// One frame per cycle while rsp_tready stays high; a frame passes the gain
// register, then the peak and lamp update. The decay multiply plus compare
// sets the loop. The lane state registers double as the result register;
// a frame can wait in the input stage behind a result. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_meter_overload_lamps #(
   parameter int SAMPLE_BITS = pmol_pkg::SAMPLE_BITS_DEF,
   parameter int HOLD_BITS   = pmol_pkg::HOLD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sample_left, sample_right, zero pad
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // peak_left, peak_right, lamp_overload_low_left, lamp_overload_high_left,
   // lamp_clip_left, lamp_overload_low_right, lamp_overload_high_right,
   // lamp_clip_right, zero pad
   output logic [((2*SAMPLE_BITS+6+7)/8)*8-1:0] rsp_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pmol_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pmol_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import pmol_pkg::*;

   localparam int OutBits   = ((2*SAMPLE_BITS+6+7)/8)*8;
   localparam int StateBits = 2*SAMPLE_BITS + 2*LAMPS_PER_LANE;

   pmol_cfg_type                  cfg;
   lane_ctl_type                  ctl_left, ctl_right;
   logic                          s1_valid_ff, s1_valid_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          adv, accept, upd;
   logic signed [SAMPLE_BITS-1:0] peak_left, peak_right;
   logic [LAMPS_PER_LANE-1:0]     lamps_left, lamps_right;
   logic [StateBits-1:0]          state_vec;

   assign csr_ready = 1'b1;

   pmol_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || adv;
   assign accept     = req_tvalid && req_tready;
   assign upd        = s1_valid_ff && adv;

   assign s1_valid_in  = accept ? 1'b1 : (s1_valid_ff && !upd);
   assign out_valid_in = upd ? 1'b1 : (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      ctl_left.audio       = (cfg.mode == MODE_AUDIO);
      ctl_left.meter_en    = 1'b1;
      ctl_left.cv_copy     = (cfg.mode == MODE_CV);
      ctl_left.low_level   = cfg.low_level;
      ctl_left.high_level  = cfg.high_level;
      ctl_left.clip_level  = cfg.clip_level;
      ctl_left.hold_frames = cfg.hold_frames;
      ctl_right            = ctl_left;
      ctl_right.meter_en   = (cfg.stereo >= STEREO_TWO);
      ctl_right.cv_copy    = 1'b0;
   end

   pmol_lane #(.SAMPLE_BITS(SAMPLE_BITS), .HOLD_BITS(HOLD_BITS)) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .in_load   (accept),
      .in_sample ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .upd       (upd),
      .ctl       (ctl_left),
      .peak      (peak_left),
      .lamps     (lamps_left)
   );

   pmol_lane #(.SAMPLE_BITS(SAMPLE_BITS), .HOLD_BITS(HOLD_BITS)) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .in_load   (accept),
      .in_sample ($signed(req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS])),
      .upd       (upd),
      .ctl       (ctl_right),
      .peak      (peak_right),
      .lamps     (lamps_right)
   );

   // merge: pack both lanes into one result
   assign state_vec  = {lamps_right, lamps_left, peak_right, peak_left};
   assign rsp_tdata  = OutBits'(state_vec);
   assign rsp_tvalid = out_valid_ff;

`include "peak_meter_overload_lamps_assert.svh"

   `PMOL_ASSERT_NOW(a_no_overrun, clock, reset, accept && s1_valid_ff, adv, "input stage overrun")
   `PMOL_ASSERT_NEXT(a_state_holds, clock, reset, !upd, $stable(state_vec), "state moved without update")
   `PMOL_ASSERT_NEXT(a_update_shown, clock, reset, upd, rsp_tvalid, "update not presented")

endmodule

`default_nettype wire

// ===== dv/peak_meter_overload_lamps_tb.sv =====
// ----------------------------------------------------------------------------
// peak_meter_overload_lamps_tb
// Drives stereo frames and register writes into the peak meter. Every result
// is checked against a cycle-free model of the peak, lamp and hold logic.
// Directed cases come first, then randomized settings with random samples,
// with random backpressure and gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module peak_meter_overload_lamps_tb;
   import pmol_pkg::*;

   localparam int REQ_BITS    = ((2*SAMPLE_BITS_DEF+7)/8)*8;
   localparam int RSP_BITS    = ((2*SAMPLE_BITS_DEF+6+7)/8)*8;
   localparam int LATENCY     = 2;
   localparam int STALL_LIMIT = 2000;
   localparam int NUM_LAMPS   = 2*LAMPS_PER_LANE;

   localparam logic [MODE_BITS-1:0]      MODE_SPARE   = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

   typedef logic signed [SAMPLE_BITS_DEF-1:0] sample_type;

   typedef struct packed {
      logic [NUM_LAMPS-1:0] lamps;
      sample_type           peak_right;
      sample_type           peak_left;
   } meter_reading_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_BITS-1:0]       req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]       rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   // model state and registers
   sample_type               peak_level [2]         = '{default: '0};
   logic                     lamp_lit [NUM_LAMPS]   = '{default: 1'b0};
   logic [HOLD_REG_BITS-1:0] hold_count [NUM_LAMPS] = '{default: '0};
   logic [MODE_BITS-1:0]     cfg_mode   = RST_MODE;
   logic [STEREO_BITS-1:0]   cfg_stereo = RST_STEREO;
   logic [LEVEL_BITS-1:0]    cfg_low    = RST_LOW;
   logic [LEVEL_BITS-1:0]    cfg_high   = RST_HIGH;
   logic [LEVEL_BITS-1:0]    cfg_clip   = RST_CLIP;
   logic [HOLD_REG_BITS-1:0] cfg_hold   = RST_HOLD;

   meter_reading_type expected_readings [$];
   meter_reading_type got_reading;
   meter_reading_type want_reading;
   int                mismatch_count = 0;
   int                quiet_cycles   = 0;
   int                ready_stall    = 0;
   bit                pacing         = 1'b1;

   string lamp_name [NUM_LAMPS] = '{
      "lamp_overload_low_left", "lamp_overload_high_left", "lamp_clip_left",
      "lamp_overload_low_right", "lamp_overload_high_right", "lamp_clip_right"
   };

   peak_meter_overload_lamps dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Q15 multiply, floor rounding
   function automatic longint q15_mul(longint x, longint k);
      return (x * k) >>> Q15_SHIFT;
   endfunction

   function automatic void meter_lane(int lane, sample_type s);
      longint scaled;
      int     base;
      scaled = q15_mul(s, GAIN_Q15);
      base   = lane * LAMPS_PER_LANE;
      if (scaled > peak_level[lane]) begin
         peak_level[lane] = sample_type'(scaled);
      end else begin
         peak_level[lane] = sample_type'(q15_mul(peak_level[lane], DECAY_Q15));
      end
      if (scaled > longint'(cfg_low))  lamp_lit[base+LAMP_LOW]  = 1'b1;
      if (scaled > longint'(cfg_high)) lamp_lit[base+LAMP_HIGH] = 1'b1;
      if (scaled > longint'(cfg_clip)) lamp_lit[base+LAMP_CLIP] = 1'b1;
   endfunction

   function automatic meter_reading_type meter_frame(sample_type left, sample_type right);
      meter_reading_type reading;
      if (cfg_mode == MODE_AUDIO) begin
         meter_lane(0, left);
         if (cfg_stereo > 1) meter_lane(1, right);
         for (int i = 0; i < NUM_LAMPS; i++) begin
            if (lamp_lit[i]) begin
               if (hold_count[i] != '1) hold_count[i] = hold_count[i] + 1'b1;
               if (hold_count[i] >= cfg_hold) begin
                  lamp_lit[i]   = 1'b0;
                  hold_count[i] = '0;
               end
            end
         end
      end else if (cfg_mode == MODE_CV) begin
         peak_level[0] = left;
      end
      reading.peak_left  = peak_level[0];
      reading.peak_right = peak_level[1];
      for (int i = 0; i < NUM_LAMPS; i++) reading.lamps[i] = lamp_lit[i];
      return reading;
   endfunction

   function automatic void set_register(logic [CSR_INDEX_BITS-1:0] idx,
                                        logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         REG_METER_MODE:    cfg_mode   = value[MODE_BITS-1:0];
         REG_STEREO_ENABLE: cfg_stereo = value[STEREO_BITS-1:0];
         REG_OVL_LOW:       cfg_low    = value[LEVEL_BITS-1:0];
         REG_OVL_HIGH:      cfg_high   = value[LEVEL_BITS-1:0];
         REG_CLIP_LEVEL:    cfg_clip   = value[LEVEL_BITS-1:0];
         REG_HOLD_FRAMES:   cfg_hold   = value[HOLD_REG_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return sample_type'(32767);
         1:       return sample_type'(-32768);
         2, 3, 4: return sample_type'($urandom_range(24000, 32767));
         5:       return sample_type'(int'($urandom_range(0, 400)) - 200);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_frame(sample_type left, sample_type right);
      int gap;
      if (pacing && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'({right, left});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_readings.push_back(meter_frame(left, right));
   endtask

   // stop sending and let every pending result drain
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx,
                            logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      set_register(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_levels();
      send_frame(0, 0);
      send_frame(32767, -32768);
      send_frame(-32768, 32767);
      send_frame(29014, 29015);   // just at and just over the low level
      send_frame(30720, 30721);
      send_frame(32767, 32767);
   endtask

   task automatic test_zero_hold();
      settle();
      write_csr(REG_HOLD_FRAMES, 16'd0);
      send_frame(32767, 32767);
      send_frame(29015, -1);
   endtask

   task automatic test_mono();
      settle();
      write_csr(REG_HOLD_FRAMES, 16'd3);
      send_frame(0, 32767);
      settle();
      write_csr(REG_STEREO_ENABLE, 16'd1);
      send_frame(0, 32767);       // right lamps keep counting, not set again
      send_frame(0, 0);
      send_frame(0, 0);
      settle();
      write_csr(REG_STEREO_ENABLE, 16'd0);
      send_frame(-5, 32767);
      settle();
      write_csr(REG_STEREO_ENABLE, 16'd3);
      send_frame(32767, 32767);
   endtask

   task automatic test_cv_mode();
      settle();
      write_csr(REG_METER_MODE, 16'(MODE_CV));
      send_frame(-32768, 5);
      send_frame(32767, 0);
      send_frame(1234, -1);
   endtask

   task automatic test_idle_modes();
      settle();
      write_csr(REG_METER_MODE, 16'(MODE_IDLE));
      send_frame(32767, 32767);
      settle();
      write_csr(REG_METER_MODE, 16'(MODE_SPARE));
      send_frame(-32768, -32768);
   endtask

   task automatic test_spare_registers();
      settle();
      write_csr(REG_SPARE_LO, 16'($urandom));
      write_csr(REG_SPARE_HI, 16'($urandom));
      write_csr(REG_METER_MODE, 16'(MODE_AUDIO));
      send_frame(32767, 32767);
   endtask

   task automatic test_random_settings();
      logic [MODE_BITS-1:0]     mode;
      logic [STEREO_BITS-1:0]   stereo;
      logic [LEVEL_BITS-1:0]    low, high, clip;
      logic [HOLD_REG_BITS-1:0] hold;
      logic [CSR_DATA_BITS-1:0] junk;
      int                       pick;
      for (int phase = 0; phase < 12; phase++) begin
         settle();
         case (phase)
            0: begin
               mode = MODE_AUDIO; stereo = 2'd2;
               low = '0; high = '0; clip = '0; hold = 16'd1;
            end
            1: begin
               mode = MODE_AUDIO; stereo = 2'd1;
               low = '1; high = '1; clip = '1; hold = '1;
            end
            default: begin
               pick   = $urandom_range(0, 9);
               mode   = (pick < 7) ? MODE_AUDIO : (pick == 7) ? MODE_CV :
                        (pick == 8) ? MODE_IDLE : MODE_SPARE;
               stereo = 2'($urandom_range(0, 3));
               low    = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                                    : 15'($urandom_range(24000, 32767));
               high   = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                                    : 15'($urandom_range(24000, 32767));
               clip   = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
                                                    : 15'($urandom_range(24000, 32767));
               hold   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 24));
            end
         endcase
         junk = 16'($urandom);
         write_csr(REG_METER_MODE,    {junk[15:MODE_BITS], mode});
         write_csr(REG_STEREO_ENABLE, {junk[15:STEREO_BITS], stereo});
         write_csr(REG_OVL_LOW,       {junk[15], low});
         write_csr(REG_OVL_HIGH,      {junk[14], high});
         write_csr(REG_CLIP_LEVEL,    {junk[13], clip});
         write_csr(REG_HOLD_FRAMES,   hold);
         if (phase == 11) pacing = 1'b0;
         for (int n = 0; n < 156; n++) begin
            if (phase == 5 && n == 78) settle();
            send_frame(pick_sample(), pick_sample());
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_levels();
      test_zero_hold();
      test_mono();
      test_cv_mode();
      test_idle_modes();
      test_spare_registers();
      test_random_settings();
      settle();
      repeat (4*LATENCY) @(posedge clock);
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // result check and receiver backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_reading = rsp_tdata[$bits(meter_reading_type)-1:0];
            if (expected_readings.size() == 0) begin
               $error("result transfer with no reading expected");
               mismatch_count++;
            end else begin
               want_reading = expected_readings.pop_front();
               if (got_reading.peak_left !== want_reading.peak_left) begin
                  $error("peak_left expected %0d actual %0d",
                         want_reading.peak_left, got_reading.peak_left);
                  mismatch_count++;
               end
               if (got_reading.peak_right !== want_reading.peak_right) begin
                  $error("peak_right expected %0d actual %0d",
                         want_reading.peak_right, got_reading.peak_right);
                  mismatch_count++;
               end
               for (int i = 0; i < NUM_LAMPS; i++) begin
                  if (got_reading.lamps[i] !== want_reading.lamps[i]) begin
                     $error("%s expected %0d actual %0d", lamp_name[i],
                            want_reading.lamps[i], got_reading.lamps[i]);
                     mismatch_count++;
                  end
               end
            end
         end
         if (ready_stall > 0) begin
            ready_stall <= ready_stall - 1;
            rsp_tready  <= 1'b0;
         end else if (pacing && $urandom_range(0, 5) == 0) begin
            ready_stall <= $urandom_range(0, 5);
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < STALL_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("status: fail");
         $finish;
      end
   end

endmodule

`default_nettype wire
